// File: hw/rtl/lfts_pkg.sv
// ----------------------------------------------------------------------------
// lfts_pkg: shared types and constants for the line follower turn sequencer
// Item and result layouts, register map, phase codes, control interface.
// ----------------------------------------------------------------------------
package lfts_pkg;

  localparam int TIMER_BITS = 14;
  localparam int TSUM_W     = TIMER_BITS + 1;
  localparam int CMP_W      = (TIMER_BITS > 14) ? TIMER_BITS : 14;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_BASE_SPEED      = 3'd0;
  localparam logic [2:0] REG_STEER_SLOW_PCT  = 3'd1;
  localparam logic [2:0] REG_TURN_SPEED_PCT  = 3'd2;
  localparam logic [2:0] REG_MIN_TURN_PWM    = 3'd3;
  localparam logic [2:0] REG_BRAKE_MS        = 3'd4;
  localparam logic [2:0] REG_APPROACH_MS     = 3'd5;
  localparam logic [2:0] REG_PAUSE_MS        = 3'd6;
  localparam logic [2:0] REG_TURN_TIMEOUT_MS = 3'd7;

  localparam logic [2:0] MODE_STOP       = 3'd0;
  localparam logic [2:0] MODE_FORWARD    = 3'd1;
  localparam logic [2:0] MODE_DIFF       = 3'd2;
  localparam logic [2:0] MODE_SPIN_LEFT  = 3'd3;
  localparam logic [2:0] MODE_SPIN_RIGHT = 3'd4;
  localparam logic [2:0] MODE_BRAKE      = 3'd5;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_TURN_DONE = 2'd1;
  localparam logic [1:0] EV_TIMEOUT   = 2'd2;
  localparam logic [1:0] EV_LINE_LOST = 2'd3;

  localparam logic [7:0] RESET_SPEED = 8'd75;

  typedef enum logic [2:0] {
    PH_FOLLOW   = 3'd0,
    PH_BRAKE    = 3'd1,
    PH_APPROACH = 3'd2,
    PH_PAUSE    = 3'd3,
    PH_SPIN     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PTS,
    ST_DIV_PTS,
    ST_MUL_PCT,
    ST_DIV_PCT,
    ST_DECIDE
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0]  base_pwm;
    logic [6:0]  steer_pct;
    logic [6:0]  spin_pct;
    logic [7:0]  min_turn_pwm;
    logic [9:0]  brake_ms;
    logic [9:0]  approach_ms;
    logic [9:0]  pause_ms;
    logic [13:0] spin_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         elapsed_ms;
    logic               mark_l;
    logic               side_l;
    logic               mid_l;
    logic               mid_r;
    logic               side_r;
    logic               mark_r;
    logic               points_valid;
    logic signed [15:0] points;
  } sample_t;

  typedef struct packed {
    logic [2:0] motor_mode;
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic [1:0] event_res;
  } result_t;

  typedef struct packed {
    logic load;
    logic mul_pts;
    logic div_pts;
    logic mul_pct;
    logic div_pct;
    logic decide;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: hw/rtl/lfts_sample_if.sv
// ----------------------------------------------------------------------------
// lfts_sample_if: sensor sample channel
// Valid/ready channel carrying one control-period item.
// ----------------------------------------------------------------------------
interface lfts_sample_if;
  import lfts_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/lfts_command_if.sv
// ----------------------------------------------------------------------------
// lfts_command_if: motor command channel
// Valid/ready channel carrying one motor command result.
// ----------------------------------------------------------------------------
interface lfts_command_if;
  import lfts_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/lfts_regs.sv
// ----------------------------------------------------------------------------
// lfts_regs: configuration register file
// APB-style write/read port for the eight tuning registers.
// ----------------------------------------------------------------------------
module lfts_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output lfts_pkg::cfg_t cfg
);
  import lfts_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_pwm        <= 8'd75;
      cfg.steer_pct       <= 7'd60;
      cfg.spin_pct        <= 7'd85;
      cfg.min_turn_pwm    <= 8'd80;
      cfg.brake_ms        <= 10'd120;
      cfg.approach_ms     <= 10'd230;
      cfg.pause_ms        <= 10'd100;
      cfg.spin_timeout_ms <= 14'd3500;
    end else if (wr) begin
      case (idx)
        REG_BASE_SPEED:      cfg.base_pwm        <= pwdata[7:0];
        REG_STEER_SLOW_PCT:  cfg.steer_pct       <= pwdata[6:0];
        REG_TURN_SPEED_PCT:  cfg.spin_pct        <= pwdata[6:0];
        REG_MIN_TURN_PWM:    cfg.min_turn_pwm    <= pwdata[7:0];
        REG_BRAKE_MS:        cfg.brake_ms        <= pwdata[9:0];
        REG_APPROACH_MS:     cfg.approach_ms     <= pwdata[9:0];
        REG_PAUSE_MS:        cfg.pause_ms        <= pwdata[9:0];
        REG_TURN_TIMEOUT_MS: cfg.spin_timeout_ms <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE_SPEED:      prdata = {24'd0, cfg.base_pwm};
      REG_STEER_SLOW_PCT:  prdata = {25'd0, cfg.steer_pct};
      REG_TURN_SPEED_PCT:  prdata = {25'd0, cfg.spin_pct};
      REG_MIN_TURN_PWM:    prdata = {24'd0, cfg.min_turn_pwm};
      REG_BRAKE_MS:        prdata = {22'd0, cfg.brake_ms};
      REG_APPROACH_MS:     prdata = {22'd0, cfg.approach_ms};
      REG_PAUSE_MS:        prdata = {22'd0, cfg.pause_ms};
      REG_TURN_TIMEOUT_MS: prdata = {18'd0, cfg.spin_timeout_ms};
      default:             prdata = 32'd0;
    endcase
  end
endmodule

// File: hw/rtl/lfts_ctrl.sv
// ----------------------------------------------------------------------------
// lfts_ctrl: sequencing controller
// Steps the datapath through speed, percentage and decision cycles per item.
// ----------------------------------------------------------------------------
module lfts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  lfts_pkg::dp_status_t status,
  output lfts_pkg::dp_cmd_t    cmd
);
  import lfts_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (sample_valid) state_next = ST_MUL_PTS;
      ST_MUL_PTS: state_next = ST_DIV_PTS;
      ST_DIV_PTS: state_next = ST_MUL_PCT;
      ST_MUL_PCT: state_next = ST_DIV_PCT;
      ST_DIV_PCT: state_next = ST_DECIDE;
      ST_DECIDE:  if (!status.out_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        cmd.load     = sample_valid;
      end
      ST_MUL_PTS: cmd.mul_pts = 1'b1;
      ST_DIV_PTS: cmd.div_pts = 1'b1;
      ST_MUL_PCT: cmd.mul_pct = 1'b1;
      ST_DIV_PCT: cmd.div_pct = 1'b1;
      ST_DECIDE:  cmd.decide  = !status.out_busy;
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/lfts_dp.sv
// ----------------------------------------------------------------------------
// lfts_dp: sequencer datapath
// Item latch, speed arithmetic, turn state, decision logic, result register.
// ----------------------------------------------------------------------------
module lfts_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lfts_pkg::cfg_t       cfg,
  input  lfts_pkg::dp_cmd_t    cmd,
  output lfts_pkg::dp_status_t status,
  input  lfts_pkg::sample_t    sample_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output lfts_pkg::result_t    result_data
);
  import lfts_pkg::*;

  // ceil(2^29/1000) and ceil(2^22/100): exact floor over the operand ranges
  localparam logic [19:0] RECIP_1000 = 20'd536871;
  localparam logic [15:0] RECIP_100  = 16'd41944;

  function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                   input logic [13:0] dur);
    logic [CMP_W-1:0] te;
    logic [CMP_W-1:0] de;
    te = CMP_W'(t);
    de = CMP_W'(dur);
    return (te >= de) || (t == TIMER_MAX);
  endfunction

  // latched item
  sample_t     item;
  logic [10:0] total;

  // arithmetic pipeline
  logic [18:0] prod_pts;
  logic [14:0] prod_slow, prod_spin;
  logic [8:0]  slow_q, spin_q;

  // block state
  phase_t                phase;
  logic                  turn_to_left;
  logic [TIMER_BITS-1:0] phase_timer;
  logic [7:0]            current_speed;

  logic signed [16:0] total_sum;
  logic [10:0]        total_clamped;
  logic [38:0]        q_pts_full;
  logic [9:0]         q_pts;
  logic [30:0]        q_slow_full, q_spin_full;

  always_comb begin
    total_sum = 17'sd1000 + {sample_data.points[15], sample_data.points};
    if (sample_data.points < -16'sd1000) begin
      total_clamped = 11'd0;
    end else if (sample_data.points > 16'sd1000) begin
      total_clamped = 11'd2000;
    end else begin
      total_clamped = total_sum[10:0];
    end
  end

  assign q_pts_full  = {20'd0, prod_pts} * {19'd0, RECIP_1000};
  assign q_pts       = q_pts_full[38:29];
  assign q_slow_full = {16'd0, prod_slow} * {15'd0, RECIP_100};
  assign q_spin_full = {16'd0, prod_spin} * {15'd0, RECIP_100};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item  <= sample_data;
      total <= total_clamped;
    end
    if (cmd.mul_pts) begin
      prod_pts <= {11'd0, cfg.base_pwm} * {8'd0, total};
    end
    if (cmd.mul_pct) begin
      prod_slow <= {7'd0, current_speed} * {8'd0, cfg.steer_pct};
      prod_spin <= {7'd0, current_speed} * {8'd0, cfg.spin_pct};
    end
    if (cmd.div_pct) begin
      slow_q <= q_slow_full[30:22];
      spin_q <= q_spin_full[30:22];
    end
  end

  // decision
  phase_t                ph;
  logic [TIMER_BITS-1:0] t;
  logic                  ttl;
  logic                  done;
  result_t               res;
  logic [TSUM_W-1:0]     tsum;
  logic [7:0]            slow_pwm, spin_pwm;
  logic [8:0]            spin_lo;

  always_comb begin
    slow_pwm = slow_q[8] ? 8'hFF : slow_q[7:0];
    spin_lo  = (spin_q < {1'b0, cfg.min_turn_pwm}) ? {1'b0, cfg.min_turn_pwm} : spin_q;
    if (current_speed == 8'd0) begin
      spin_pwm = 8'd0;
    end else begin
      spin_pwm = spin_lo[8] ? 8'hFF : spin_lo[7:0];
    end
  end

  always_comb begin
    ph   = phase;
    t    = phase_timer;
    ttl  = turn_to_left;
    done = 1'b0;
    res  = '{motor_mode: MODE_STOP, left_pwm: 8'd0, right_pwm: 8'd0, event_res: EV_NONE};
    tsum = {1'b0, phase_timer} + TSUM_W'(item.elapsed_ms);

    if (phase == PH_FOLLOW) begin
      if (current_speed == 8'd0) begin
        done = 1'b1;
      end else if (item.mark_l || item.mark_r) begin
        ttl = item.mark_l;
        ph  = PH_BRAKE;
        t   = '0;
      end else begin
        done = 1'b1;
        if (item.side_l && !item.side_r) begin
          res = '{motor_mode: MODE_DIFF, left_pwm: slow_pwm,
                  right_pwm: current_speed, event_res: EV_NONE};
        end else if (item.side_r && !item.side_l) begin
          res = '{motor_mode: MODE_DIFF, left_pwm: current_speed,
                  right_pwm: slow_pwm, event_res: EV_NONE};
        end else if (item.mid_l || item.mid_r) begin
          res = '{motor_mode: MODE_FORWARD, left_pwm: current_speed,
                  right_pwm: current_speed, event_res: EV_NONE};
        end else begin
          res.event_res = EV_LINE_LOST;
        end
      end
    end else begin
      t = tsum[TIMER_BITS] ? TIMER_MAX : tsum[TIMER_BITS-1:0];
    end

    if (!done) begin
      // several timed phases may end within one period
      if (ph == PH_BRAKE && reached(t, {4'd0, cfg.brake_ms})) begin
        ph = PH_APPROACH;
        t  = '0;
      end
      if (ph == PH_APPROACH && reached(t, {4'd0, cfg.approach_ms})) begin
        ph = PH_PAUSE;
        t  = '0;
      end
      if (ph == PH_PAUSE && reached(t, {4'd0, cfg.pause_ms})) begin
        ph = PH_SPIN;
        t  = '0;
      end
      case (ph)
        PH_BRAKE:    res.motor_mode = MODE_BRAKE;
        PH_APPROACH: res = '{motor_mode: MODE_FORWARD, left_pwm: current_speed,
                             right_pwm: current_speed, event_res: EV_NONE};
        PH_PAUSE:    res.motor_mode = MODE_STOP;
        default: begin
          if (reached(t, cfg.spin_timeout_ms)) begin
            ph = PH_FOLLOW;
            t  = '0;
            res.event_res = EV_TIMEOUT;
          end else if (item.mid_l || item.mid_r) begin
            ph = PH_FOLLOW;
            t  = '0;
            res.event_res = EV_TURN_DONE;
          end else if (spin_pwm == 8'd0) begin
            ph = PH_FOLLOW;
            t  = '0;
          end else begin
            res = '{motor_mode: ttl ? MODE_SPIN_LEFT : MODE_SPIN_RIGHT,
                    left_pwm: spin_pwm, right_pwm: spin_pwm, event_res: EV_NONE};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FOLLOW;
      turn_to_left  <= 1'b0;
      phase_timer   <= '0;
      current_speed <= RESET_SPEED;
      result_valid  <= 1'b0;
    end else begin
      if (cmd.div_pts && phase == PH_FOLLOW && item.points_valid) begin
        current_speed <= (q_pts > 10'd255) ? 8'hFF : q_pts[7:0];
      end
      if (cmd.decide) begin
        phase        <= ph;
        phase_timer  <= t;
        turn_to_left <= ttl;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      result_data <= res;
    end
  end

  assign status.out_busy = result_valid && !result_ready;
endmodule

// File: hw/rtl/line_follower_turn_sequencer_top.sv
// ----------------------------------------------------------------------------
// line_follower_turn_sequencer_top: line follower turn sequencer
// Per-period steering, turn sequencing and points-based speed control.
// ----------------------------------------------------------------------------
// Usage:
//  - sample: one item per control period (elapsed ms, six line sensors,
//    optional points update). Transfer when valid and ready are high.
//  - command: one motor command per sample (mode, two PWM duties, event).
//  - APB-style port: eight tuning registers at byte address 4*index;
//    write only while no item is in flight. pready is tied high.
// Sequence: after a sample transfer the controller walks the shared steps
//  in order: points multiply, divide by 1000, percentage multiplies,
//  divide by 100, decide. The command is registered in the decide step,
//  and the next sample is accepted only once the decide step is done.
// Stall: the command register holds its result until taken; the next
//  sample is still accepted and computed, and only the decide step waits
//  for the command register to free up.
// Reset (rst, synchronous): follow phase, speed 75, timer cleared,
//  registers at their defaults, no command pending.
// ----------------------------------------------------------------------------
module line_follower_turn_sequencer_top (
  input  logic          clk,
  input  logic          rst,
  lfts_sample_if.sink   sample,
  lfts_command_if.source command,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import lfts_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // tuning registers
  lfts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // step sequencer; ready only in its idle state
  lfts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic, turn state and the command register
  lfts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .sample_data  (sample.data),
    .result_valid (command.valid),
    .result_ready (command.ready),
    .result_data  (command.data)
  );
endmodule
